// ===== rtl/stdo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stdo_pkg;

   // Default widths of the signal and coefficient formats.
   localparam int SIGNAL_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF   = 48;

   // Fixed internal formats.
   localparam int LIM_WIDTH   = 32;
   localparam int ACC_WIDTH   = 48;
   localparam int SUM_WIDTH   = 50;
   localparam int OPB_WIDTH   = 64;
   localparam int PROD_WIDTH  = 128;
   localparam int DIGIT_WIDTH = 16;
   localparam int DIGIT_COUNT = OPB_WIDTH / DIGIT_WIDTH;
   localparam int COEF_FRAC   = 24;
   localparam int DSTEP_SHIFT = 8;
   localparam int SIG_FRAC    = 16;

   // Square-root unit.
   localparam int RAD_WIDTH    = 64;
   localparam int ROOT_WIDTH   = RAD_WIDTH / 2;
   localparam int REM_WIDTH    = ROOT_WIDTH + 2;
   localparam int MAG_CAP_BITS = 47;

   // Register file.
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int REG_IDX_WIDTH  = 3;

   localparam logic [REG_IDX_WIDTH-1:0] REG_CURRENT_GAIN       = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_INVERSE_INERTIA    = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_MODEL_NUMERATOR    = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_MODEL_POLE         = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_DISTURBANCE_STEP   = 3'd4;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROOT_GAIN          = 3'd5;
   localparam logic [REG_IDX_WIDTH-1:0] REG_DISTURBANCE_LIMITS = 3'd6;
   localparam logic [REG_IDX_WIDTH-1:0] REG_SPEED_LIMITS       = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DSTEP,
      ST_P0,
      ST_P1,
      ST_ROOT,
      ST_RWAIT,
      ST_P2,
      ST_MSUM,
      ST_T1,
      ST_T2,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_DIGIT,
      MUL_SIGN,
      MUL_ROUND
   } mul_state_type;

   typedef struct packed {
      logic start;
      logic short_shift;
   } mul_cmd_type;

   // Clamp to a packed pair of signed limits, maximum in the upper half.
   function automatic logic signed [LIM_WIDTH-1:0] clamp_lim(
      input logic signed [SUM_WIDTH-1:0] x,
      input logic [2*LIM_WIDTH-1:0]      lim
   );
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      logic signed [LIM_WIDTH-1:0] r;
      hi = SUM_WIDTH'(signed'(lim[2*LIM_WIDTH-1:LIM_WIDTH]));
      lo = SUM_WIDTH'(signed'(lim[LIM_WIDTH-1:0]));
      if (x > hi) begin
         r = hi[LIM_WIDTH-1:0];
      end else if (x < lo) begin
         r = lo[LIM_WIDTH-1:0];
      end else begin
         r = x[LIM_WIDTH-1:0];
      end
      return r;
   endfunction

   // Saturate a wide sum to the accumulator format.
   function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
      input logic signed [SUM_WIDTH-1:0] x
   );
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      logic signed [ACC_WIDTH-1:0] r;
      hi = (SUM_WIDTH'(1) << (ACC_WIDTH - 1)) - SUM_WIDTH'(1);
      lo = -hi - SUM_WIDTH'(1);
      if (x > hi) begin
         r = hi[ACC_WIDTH-1:0];
      end else if (x < lo) begin
         r = lo[ACC_WIDTH-1:0];
      end else begin
         r = x[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/stdo_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stdo_mul #(
   parameter int COEF_WIDTH = stdo_pkg::COEF_WIDTH_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire stdo_pkg::mul_cmd_type                   cmd,
   input  wire logic signed [COEF_WIDTH-1:0]            coef,
   input  wire logic signed [stdo_pkg::OPB_WIDTH-1:0]   operand,
   output logic                                         done,
   output logic signed [stdo_pkg::ACC_WIDTH-1:0]        result
);

   localparam int OPB   = stdo_pkg::OPB_WIDTH;
   localparam int PROD  = stdo_pkg::PROD_WIDTH;
   localparam int DIG   = stdo_pkg::DIGIT_WIDTH;
   localparam int CNTW  = $clog2(stdo_pkg::DIGIT_COUNT);
   localparam int ACC   = stdo_pkg::ACC_WIDTH;
   localparam int RNDW  = PROD + 2;

   stdo_pkg::mul_state_type state_ff, state_in;
   logic [OPB-1:0]          amag_ff, amag_in;
   logic [OPB-1:0]          bmag_ff, bmag_in;
   logic                    neg_ff, neg_in;
   logic                    short_ff, short_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic [PROD-1:0]         acc_ff, acc_in;
   logic signed [PROD:0]    prod_ff, prod_in;
   logic signed [ACC-1:0]   result_ff, result_in;
   logic                    done_ff, done_in;

   logic signed [OPB-1:0]   a_ext;
   logic [OPB+DIG-1:0]      partial;
   logic signed [RNDW-1:0]  rnd_sum;
   logic signed [RNDW-1:0]  rnd_val;
   logic signed [RNDW-1:0]  sat_hi;
   logic signed [RNDW-1:0]  sat_lo;

   // One digit of the operand per cycle, most significant first, then sign and rounding.
   always_comb begin
      state_in  = state_ff;
      amag_in   = amag_ff;
      bmag_in   = bmag_ff;
      neg_in    = neg_ff;
      short_in  = short_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      result_in = result_ff;
      done_in   = 1'b0;

      a_ext   = OPB'(coef);
      partial = amag_ff * bmag_ff[OPB-1:OPB-DIG];
      rnd_sum = RNDW'(prod_ff) + (short_ff ? (RNDW'(1) << (stdo_pkg::DSTEP_SHIFT - 1))
                                           : (RNDW'(1) << (stdo_pkg::COEF_FRAC - 1)));
      rnd_val = short_ff ? (rnd_sum >>> stdo_pkg::DSTEP_SHIFT)
                         : (rnd_sum >>> stdo_pkg::COEF_FRAC);
      sat_hi  = (RNDW'(1) << (ACC - 1)) - RNDW'(1);
      sat_lo  = -sat_hi - RNDW'(1);

      case (state_ff)
         stdo_pkg::MUL_IDLE: begin
            if (cmd.start) begin
               amag_in  = a_ext[OPB-1] ? (~a_ext + OPB'(1)) : a_ext;
               bmag_in  = operand[OPB-1] ? (~operand + OPB'(1)) : operand;
               neg_in   = a_ext[OPB-1] ^ operand[OPB-1];
               short_in = cmd.short_shift;
               cnt_in   = '0;
               acc_in   = '0;
               state_in = stdo_pkg::MUL_DIGIT;
            end
         end
         stdo_pkg::MUL_DIGIT: begin
            acc_in  = {acc_ff[PROD-DIG-1:0], {DIG{1'b0}}} + PROD'(partial);
            bmag_in = {bmag_ff[OPB-DIG-1:0], {DIG{1'b0}}};
            cnt_in  = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(stdo_pkg::DIGIT_COUNT - 1)) begin
               state_in = stdo_pkg::MUL_SIGN;
            end
         end
         stdo_pkg::MUL_SIGN: begin
            prod_in  = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
            state_in = stdo_pkg::MUL_ROUND;
         end
         stdo_pkg::MUL_ROUND: begin
            if (rnd_val > sat_hi) begin
               result_in = sat_hi[ACC-1:0];
            end else if (rnd_val < sat_lo) begin
               result_in = sat_lo[ACC-1:0];
            end else begin
               result_in = rnd_val[ACC-1:0];
            end
            done_in  = 1'b1;
            state_in = stdo_pkg::MUL_IDLE;
         end
         default: begin
            state_in = stdo_pkg::MUL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stdo_pkg::MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      amag_ff   <= amag_in;
      bmag_ff   <= bmag_in;
      neg_ff    <= neg_in;
      short_ff  <= short_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/super_twisting_disturbance_observer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Super-twisting sliding-mode disturbance observer. Each request carries the q-axis
// current and the measured speed (signed Q16.16) and yields one response with the clamped
// disturbance torque estimate and the clamped observed speed. The block handles one
// request at a time: the response is raised after the last product, and the next request
// can be accepted as soon as the response is raised; a stalled response holds the block
// until it is taken. The pace is set by the square-root unit, which runs alongside the
// first three products, and by six products that pass in turn through one shared
// multiplier, each through four 64 x 16 bit digit steps, a sign step, a rounding step and
// the registered result; the root product waits for the square root to settle. The
// coefficients are Q24.24 values worked out by software and written through the register
// port, which should be written only while no request is in progress.
module super_twisting_disturbance_observer #(
   parameter  int SIGNAL_WIDTH = stdo_pkg::SIGNAL_WIDTH_DEF,
   parameter  int COEF_WIDTH   = stdo_pkg::COEF_WIDTH_DEF,
   localparam int TDATA_WIDTH  = ((2 * SIGNAL_WIDTH + 7) / 8) * 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request channel.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // current_q, speed_meas
   input  wire logic [TDATA_WIDTH-1:0]                req_tdata,
   // Response channel.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // disturbance_est, speed_est
   output logic [TDATA_WIDTH-1:0]                     rsp_tdata,
   // Register port.
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [stdo_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [stdo_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [stdo_pkg::CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                                       csr_pready
);

   localparam int SW    = SIGNAL_WIDTH;
   localparam int LIM   = stdo_pkg::LIM_WIDTH;
   localparam int ACC   = stdo_pkg::ACC_WIDTH;
   localparam int SUMW  = stdo_pkg::SUM_WIDTH;
   localparam int OPB   = stdo_pkg::OPB_WIDTH;
   localparam int DW    = stdo_pkg::CSR_DATA_WIDTH;
   localparam int ERRW  = ((SW > LIM) ? SW : LIM) + 1;
   localparam int RAD   = stdo_pkg::RAD_WIDTH;
   localparam int ROOTW = stdo_pkg::ROOT_WIDTH;
   localparam int REMW  = stdo_pkg::REM_WIDTH;
   localparam int SQCW  = $clog2(ROOTW);
   localparam int CAPB  = stdo_pkg::MAG_CAP_BITS;

   // Configuration registers.
   logic signed [COEF_WIDTH-1:0] cgain_ff, iinert_ff, mnum_ff, mpole_ff, dstep_ff, rgain_ff;
   logic [2*LIM-1:0]             dlim_ff, slim_ff;
   logic                         csr_write;

   // Sequencer and datapath.
   stdo_pkg::state_type     state_ff, state_in;
   logic signed [SW-1:0]    cur_ff, cur_in, meas_ff, meas_in;
   logic signed [1:0]       sgn_ff, sgn_in, psign_ff, psign_in;
   logic signed [LIM-1:0]   dist_ff, dist_in, speed_ff, speed_in, d_ff, d_in;
   logic signed [ACC-1:0]   pmi_ff, pmi_in, p0_ff, p0_in, m_ff, m_in;
   logic signed [ACC-1:0]   t1_ff, t1_in, t2_ff, t2_in;
   logic signed [ACC:0]     macc_ff, macc_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [SW-1:0]    rsp_dist_ff, rsp_dist_in, rsp_speed_ff, rsp_speed_in;

   // Square-root unit.
   logic                    sq_start;
   logic                    sq_busy_ff, sq_busy_in;
   logic [SQCW-1:0]         sq_cnt_ff, sq_cnt_in;
   logic [RAD-1:0]          sq_rad_ff, sq_rad_in;
   logic [REMW-1:0]         sq_rem_ff, sq_rem_in;
   logic [ROOTW-1:0]        sq_root_ff, sq_root_in;
   logic [REMW+1:0]         sq_shift;
   logic [REMW+1:0]         sq_trial;

   // Shared multiplier.
   stdo_pkg::mul_cmd_type        mul_cmd;
   logic signed [COEF_WIDTH-1:0] mul_coef;
   logic signed [OPB-1:0]        mul_operand;
   logic                         mul_done;
   logic signed [ACC-1:0]        mul_res;

   // Working values.
   logic signed [ERRW-1:0]  err;
   logic [ERRW-1:0]         mag;
   logic [OPB-1:0]          mag_ext;
   logic [OPB-1:0]          mag_cap;
   logic signed [1:0]       sgn_now;
   logic signed [2:0]       sgn_sum;
   logic signed [ACC:0]     model_in;
   logic signed [LIM-1:0]   w_val;
   logic                    out_free;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cgain_ff  <= '0;
         iinert_ff <= '0;
         mnum_ff   <= '0;
         mpole_ff  <= '0;
         dstep_ff  <= '0;
         rgain_ff  <= '0;
         dlim_ff   <= '0;
         slim_ff   <= '0;
      end else if (csr_write) begin
         case (csr_paddr[stdo_pkg::CSR_ADDR_WIDTH-1:3])
            stdo_pkg::REG_CURRENT_GAIN:       cgain_ff  <= csr_pwdata[COEF_WIDTH-1:0];
            stdo_pkg::REG_INVERSE_INERTIA:    iinert_ff <= csr_pwdata[COEF_WIDTH-1:0];
            stdo_pkg::REG_MODEL_NUMERATOR:    mnum_ff   <= csr_pwdata[COEF_WIDTH-1:0];
            stdo_pkg::REG_MODEL_POLE:         mpole_ff  <= csr_pwdata[COEF_WIDTH-1:0];
            stdo_pkg::REG_DISTURBANCE_STEP:   dstep_ff  <= csr_pwdata[COEF_WIDTH-1:0];
            stdo_pkg::REG_ROOT_GAIN:          rgain_ff  <= csr_pwdata[COEF_WIDTH-1:0];
            stdo_pkg::REG_DISTURBANCE_LIMITS: dlim_ff   <= csr_pwdata[2*LIM-1:0];
            stdo_pkg::REG_SPEED_LIMITS:       slim_ff   <= csr_pwdata[2*LIM-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (csr_paddr[stdo_pkg::CSR_ADDR_WIDTH-1:3])
         stdo_pkg::REG_CURRENT_GAIN:       csr_prdata = DW'(cgain_ff);
         stdo_pkg::REG_INVERSE_INERTIA:    csr_prdata = DW'(iinert_ff);
         stdo_pkg::REG_MODEL_NUMERATOR:    csr_prdata = DW'(mnum_ff);
         stdo_pkg::REG_MODEL_POLE:         csr_prdata = DW'(mpole_ff);
         stdo_pkg::REG_DISTURBANCE_STEP:   csr_prdata = DW'(dstep_ff);
         stdo_pkg::REG_ROOT_GAIN:          csr_prdata = DW'(rgain_ff);
         stdo_pkg::REG_DISTURBANCE_LIMITS: csr_prdata = DW'(dlim_ff);
         stdo_pkg::REG_SPEED_LIMITS:       csr_prdata = DW'(slim_ff);
         default:                          csr_prdata = '0;
      endcase
   end

   stdo_mul #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .coef    (mul_coef),
      .operand (mul_operand),
      .done    (mul_done),
      .result  (mul_res)
   );

   // Speed error, its sign and the capped radicand for the root.
   always_comb begin
      err = ERRW'(speed_ff) - ERRW'(meas_ff);
      if (err > ERRW'(0)) begin
         sgn_now = 2'b01;
      end else if (err < ERRW'(0)) begin
         sgn_now = 2'b11;
      end else begin
         sgn_now = 2'b00;
      end
      mag     = err[ERRW-1] ? (~err + ERRW'(1)) : err;
      mag_ext = OPB'(mag);
      mag_cap = (mag_ext > ((OPB'(1) << CAPB) - OPB'(1))) ? ((OPB'(1) << CAPB) - OPB'(1))
                                                          : mag_ext;
      sgn_sum = 3'(sgn_ff) + 3'(psign_ff);
      model_in = (ACC + 1)'(m_ff) + (ACC + 1)'(pmi_ff);
      w_val    = stdo_pkg::clamp_lim(SUMW'(t1_ff) + SUMW'(t2_ff), slim_ff);
      out_free = !rsp_tvalid_ff || rsp_tready;
   end

   // Square root, two radicand bits per cycle.
   always_comb begin
      sq_busy_in = sq_busy_ff;
      sq_cnt_in  = sq_cnt_ff;
      sq_rad_in  = sq_rad_ff;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;
      sq_shift   = {sq_rem_ff, sq_rad_ff[RAD-1:RAD-2]};
      sq_trial   = (REMW + 2)'({sq_root_ff, 2'b01});
      if (sq_start) begin
         sq_busy_in = 1'b1;
         sq_cnt_in  = '0;
         sq_rad_in  = RAD'({mag_cap[CAPB-1:0], {stdo_pkg::SIG_FRAC{1'b0}}});
         sq_rem_in  = '0;
         sq_root_in = '0;
      end else if (sq_busy_ff) begin
         if (sq_shift >= sq_trial) begin
            sq_rem_in  = REMW'(sq_shift - sq_trial);
            sq_root_in = {sq_root_ff[ROOTW-2:0], 1'b1};
         end else begin
            sq_rem_in  = REMW'(sq_shift);
            sq_root_in = {sq_root_ff[ROOTW-2:0], 1'b0};
         end
         sq_rad_in = {sq_rad_ff[RAD-3:0], 2'b00};
         sq_cnt_in = sq_cnt_ff + SQCW'(1);
         if (sq_cnt_ff == SQCW'(ROOTW - 1)) begin
            sq_busy_in = 1'b0;
         end
      end
   end

   // Sequencer: six products through the shared multiplier, then the response.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      meas_in       = meas_ff;
      sgn_in        = sgn_ff;
      psign_in      = psign_ff;
      dist_in       = dist_ff;
      speed_in      = speed_ff;
      d_in          = d_ff;
      pmi_in        = pmi_ff;
      p0_in         = p0_ff;
      macc_in       = macc_ff;
      m_in          = m_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_dist_in   = rsp_dist_ff;
      rsp_speed_in  = rsp_speed_ff;
      sq_start      = 1'b0;
      mul_cmd       = '0;
      mul_coef      = '0;
      mul_operand   = '0;
      req_tready    = 1'b0;

      case (state_ff)
         stdo_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cur_in   = req_tdata[SW-1:0];
               meas_in  = req_tdata[2*SW-1:SW];
               state_in = stdo_pkg::ST_PREP;
            end
         end
         stdo_pkg::ST_PREP: begin
            sgn_in   = sgn_now;
            sq_start = 1'b1;
            state_in = stdo_pkg::ST_DSTEP;
         end
         stdo_pkg::ST_DSTEP: begin
            // The integrator step is issued here once the new sign is held.
            mul_cmd.start       = 1'b1;
            mul_cmd.short_shift = 1'b1;
            mul_coef            = dstep_ff;
            mul_operand         = OPB'(sgn_sum);
            state_in            = stdo_pkg::ST_P0;
         end
         stdo_pkg::ST_P0: begin
            if (mul_done) begin
               d_in          = stdo_pkg::clamp_lim(SUMW'(dist_ff) + SUMW'(mul_res), dlim_ff);
               mul_cmd.start = 1'b1;
               mul_coef      = cgain_ff;
               mul_operand   = OPB'(cur_ff);
               state_in      = stdo_pkg::ST_P1;
            end
         end
         stdo_pkg::ST_P1: begin
            if (mul_done) begin
               p0_in         = mul_res;
               mul_cmd.start = 1'b1;
               mul_coef      = iinert_ff;
               mul_operand   = OPB'(d_ff);
               state_in      = stdo_pkg::ST_ROOT;
            end
         end
         stdo_pkg::ST_ROOT: begin
            // Collect the inertia product.
            if (mul_done) begin
               macc_in  = (ACC + 1)'(p0_ff) - (ACC + 1)'(mul_res);
               state_in = stdo_pkg::ST_RWAIT;
            end
         end
         stdo_pkg::ST_RWAIT: begin
            // Issue the root product once the square root has settled.
            if (!sq_busy_ff) begin
               mul_cmd.start = 1'b1;
               mul_coef      = rgain_ff;
               mul_operand   = sgn_ff[1] ? (~OPB'(sq_root_ff) + OPB'(1)) : OPB'(sq_root_ff);
               state_in      = stdo_pkg::ST_P2;
            end
         end
         stdo_pkg::ST_P2: begin
            if (mul_done) begin
               m_in     = stdo_pkg::sat_acc(SUMW'(macc_ff) - SUMW'(mul_res));
               state_in = stdo_pkg::ST_MSUM;
            end
         end
         stdo_pkg::ST_MSUM: begin
            mul_cmd.start = 1'b1;
            mul_coef      = mnum_ff;
            mul_operand   = OPB'(model_in);
            state_in      = stdo_pkg::ST_T1;
         end
         stdo_pkg::ST_T1: begin
            if (mul_done) begin
               t1_in         = mul_res;
               mul_cmd.start = 1'b1;
               mul_coef      = mpole_ff;
               mul_operand   = OPB'(speed_ff);
               state_in      = stdo_pkg::ST_T2;
            end
         end
         stdo_pkg::ST_T2: begin
            if (mul_done) begin
               t2_in    = mul_res;
               state_in = stdo_pkg::ST_OUT;
            end
         end
         stdo_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_dist_in   = SW'(d_ff);
               rsp_speed_in  = SW'(w_val);
               dist_in       = d_ff;
               speed_in      = w_val;
               psign_in      = sgn_ff;
               pmi_in        = m_ff;
               state_in      = stdo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stdo_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stdo_pkg::ST_IDLE;
         sq_busy_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         psign_ff      <= '0;
         dist_ff       <= '0;
         speed_ff      <= '0;
         pmi_ff        <= '0;
         macc_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         sq_busy_ff    <= sq_busy_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         psign_ff      <= psign_in;
         dist_ff       <= dist_in;
         speed_ff      <= speed_in;
         pmi_ff        <= pmi_in;
         macc_ff       <= macc_in;
      end
      cur_ff       <= cur_in;
      meas_ff      <= meas_in;
      sgn_ff       <= sgn_in;
      d_ff         <= d_in;
      p0_ff        <= p0_in;
      m_ff         <= m_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_speed_ff <= rsp_speed_in;
      sq_cnt_ff    <= sq_cnt_in;
      sq_rad_ff    <= sq_rad_in;
      sq_rem_ff    <= sq_rem_in;
      sq_root_ff   <= sq_root_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = TDATA_WIDTH'({rsp_speed_ff, rsp_dist_ff});

   // An accepted request always moves the sequencer on to the error stage.
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == stdo_pkg::ST_PREP))
      else $error("accepted request did not start the sequence");

   // The root unit is always finished by the time the block is free again.
   a_root_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stdo_pkg::ST_IDLE) |-> !sq_busy_ff)
      else $error("square-root unit busy while idle");

   // Finishing a sample raises the response and frees the block.
   a_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stdo_pkg::ST_OUT && out_free)
      |=> (rsp_tvalid && state_ff == stdo_pkg::ST_IDLE))
      else $error("sample result not committed");

   // The multiplier is not started from the model-sum state while it is still delivering a product.
   a_mul_start: assert property (@(posedge clock) disable iff (reset)
      (mul_cmd.start && state_ff == stdo_pkg::ST_MSUM) |-> !mul_done)
      else $error("multiplier restarted during a product");

endmodule

`default_nettype wire
